// File: rtl/core/sweeping_echo_range_window_assert.svh
// ----------------------------------------------------------------------------
// sweeping echo range window assertion macros
// concurrent checks with a clock and an active-low reset, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef SWEEPING_ECHO_RANGE_WINDOW_ASSERT_SVH
`define SWEEPING_ECHO_RANGE_WINDOW_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every edge outside reset
`define SEWR_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true outside reset
`define SEWR_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SEWR_ASSERT(label, clk, rst_n, prop, msg)
`define SEWR_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// File: rtl/core/sewr_pkg.sv
// ----------------------------------------------------------------------------
// sewr_pkg
// shared types and constants of the sweeping echo range window block
// ----------------------------------------------------------------------------
`default_nettype none

package sewr_pkg;

	localparam int STEPS_DEF    = 16;
	localparam int TS_W         = 32;
	localparam int RANGE_W      = 16;
	localparam int SCALE_W      = 16;
	localparam int STEP_OUT_W   = 4;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;
	localparam int IN_TDATA_W   = 40;
	localparam int OUT_TDATA_W  = 32;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd11239;

	typedef enum logic [1:0] {
		KIND_TICK,
		KIND_ECHO_RISE,
		KIND_ECHO_FALL,
		KIND_SET_MODE
	} kind_t;

	typedef enum logic [1:0] {
		MODE_STOP,
		MODE_STEADY,
		MODE_SWEEP
	} mode_t;

	typedef enum logic [1:0] {
		SW_STOPPED,
		SW_STEADY,
		SW_SWEEPING
	} sweep_state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RANGE_MIN,
		REG_RANGE_MAX,
		REG_SCALE,
		REG_ENTER_EN,
		REG_LEAVE_EN
	} cfg_reg_t;

	// command to the sweep unit for the item in work
	typedef struct packed {
		logic                  tick;
		logic                  set_mode;
		logic [1:0]            mode;
		logic [STEP_OUT_W-1:0] target;
	} sweep_cmd_t;

	// result of one echo measurement
	typedef struct packed {
		logic [RANGE_W-1:0] range_mm;
		logic               in_win;
	} range_res_t;

endpackage

`default_nettype wire

// File: rtl/core/sweeping_echo_range_window.sv
// ----------------------------------------------------------------------------
// sweeping_echo_range_window
// ultrasonic echo ranging with a bouncing sweep position and distance window
// ----------------------------------------------------------------------------
// usage
//   s_* carries event items: tuser is the kind (tick, echo rise, echo fall,
//   set mode), tdata the echo timestamp, mode and target step
//   m_* returns exactly one result item per event item: position, heading,
//   range and window flags in tdata, tuser high when the item measured
//   cfg_* writes the window bounds, scale and pulse enables; write only while idle (not enforced by the block)
// pipeline and throughput
//   an item is registered, worked on combinationally (one 32x16 multiply and
//   two compares) and its result lands in the output register, which drives
//   m_tvalid; one item per cycle sustained while the receiver takes results
// reset
//   sweep stopped at step 0 going up, no measurement, window bounds 0,
//   scale 11239, pulses disabled, both channels empty
// stall
//   a held result keeps its output register; one more item waits in the
//   input register, then s_tready drops until the receiver takes the result
// ----------------------------------------------------------------------------
`default_nettype none
`include "sweeping_echo_range_window_assert.svh"

module sweeping_echo_range_window import sewr_pkg::*; #(
	parameter int STEPS = STEPS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// event items
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// timestamp_us [31:0], mode [33:32], target_step [37:34], zero [39:38]
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// kind [1:0]
	input  wire logic [1:0]             s_tuser,
	// result items
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// position [3:0], heading [7:4], range_mm [23:8], in_window [24],
	// entered [25], departed [26], zero [31:27]
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	// measured [0]
	output logic [0:0]                  m_tuser,
	// configuration writes
	input  wire logic                   cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int SW = $clog2(STEPS);

	// configuration registers
	logic [RANGE_W-1:0] range_min_q;
	logic [RANGE_W-1:0] range_max_q;
	logic [SCALE_W-1:0] scale_q;
	logic               enter_en_q;
	logic               leave_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q <= '0;
			range_max_q <= '0;
			scale_q     <= SCALE_RESET;
			enter_en_q  <= 1'b0;
			leave_en_q  <= 1'b0;
		end else if (cfg_wen) begin
			case (cfg_reg_t'(cfg_index))
				REG_RANGE_MIN: range_min_q <= cfg_wdata[RANGE_W-1:0];
				REG_RANGE_MAX: range_max_q <= cfg_wdata[RANGE_W-1:0];
				REG_SCALE:     scale_q     <= cfg_wdata[SCALE_W-1:0];
				REG_ENTER_EN:  enter_en_q  <= cfg_wdata[0];
				REG_LEAVE_EN:  leave_en_q  <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// input register
	logic                  valid_s1;
	kind_t                 kind_s1;
	logic [TS_W-1:0]       ts_s1;
	logic [1:0]            mode_s1;
	logic [STEP_OUT_W-1:0] target_s1;

	// the item in the input register moves on when the output slot is free
	logic adv;
	logic proc;

	assign adv      = !m_tvalid || m_tready;
	assign proc     = valid_s1 && adv;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1   <= kind_t'(s_tuser);
			ts_s1     <= s_tdata[TS_W-1:0];
			mode_s1   <= s_tdata[TS_W+1:TS_W];
			target_s1 <= s_tdata[TS_W+5:TS_W+2];
		end
	end

	// sweep position
	sweep_cmd_t    sweep_cmd;
	logic [SW-1:0] step_cur;
	logic [SW-1:0] step_nxt;

	assign sweep_cmd.tick     = (kind_s1 == KIND_TICK);
	assign sweep_cmd.set_mode = (kind_s1 == KIND_SET_MODE);
	assign sweep_cmd.mode     = mode_s1;
	assign sweep_cmd.target   = target_s1;

	sewr_sweep #(
		.STEPS (STEPS)
	) u_sweep (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (proc),
		.cmd      (sweep_cmd),
		.step_cur (step_cur),
		.step_nxt (step_nxt)
	);

	// echo timing and latest measurement
	logic [TS_W-1:0]       echo_start_q;
	logic                  inside_q;
	logic [STEP_OUT_W-1:0] last_heading_q;
	logic [RANGE_W-1:0]    last_range_q;
	range_res_t            meas;
	logic                  is_rise;
	logic                  is_fall;

	assign is_rise = (kind_s1 == KIND_ECHO_RISE);
	assign is_fall = (kind_s1 == KIND_ECHO_FALL);

	sewr_range u_range (
		.fall_us      (ts_s1),
		.rise_us      (echo_start_q),
		.scale_q16    (scale_q),
		.range_min_mm (range_min_q),
		.range_max_mm (range_max_q),
		.res          (meas)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_start_q   <= '0;
			inside_q       <= 1'b0;
			last_heading_q <= '0;
			last_range_q   <= '0;
		end else if (proc) begin
			if (is_rise) begin
				echo_start_q <= ts_s1;
			end
			if (is_fall) begin
				inside_q       <= meas.in_win;
				last_heading_q <= STEP_OUT_W'(step_cur);
				last_range_q   <= meas.range_mm;
			end
		end
	end

	// output register
	logic [STEP_OUT_W-1:0] position_q;
	logic                  measured_q;
	logic [STEP_OUT_W-1:0] heading_q;
	logic [RANGE_W-1:0]    range_q;
	logic                  in_window_q;
	logic                  entered_q;
	logic                  departed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (proc) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			position_q  <= STEP_OUT_W'(step_nxt);
			measured_q  <= is_fall;
			// non-measuring items repeat the latest measurement
			heading_q   <= is_fall ? STEP_OUT_W'(step_cur) : last_heading_q;
			range_q     <= is_fall ? meas.range_mm : last_range_q;
			in_window_q <= is_fall ? meas.in_win : inside_q;
			entered_q   <= is_fall && meas.in_win && !inside_q && enter_en_q;
			departed_q  <= is_fall && !meas.in_win && inside_q && leave_en_q;
		end
	end

	assign m_tdata = {5'b0, departed_q, entered_q, in_window_q, range_q,
		heading_q, position_q};
	assign m_tuser = measured_q;

	`SEWR_NEVER(a_pulse_excl, clk, arst_n, m_tvalid && entered_q && departed_q, "enter and leave pulse together")
	`SEWR_ASSERT(a_enter_inside, clk, arst_n, (m_tvalid && entered_q) |-> (measured_q && in_window_q), "enter pulse outside window")
	`SEWR_ASSERT(a_leave_outside, clk, arst_n, (m_tvalid && departed_q) |-> (measured_q && !in_window_q), "leave pulse inside window")
	`SEWR_ASSERT(a_stall_blocks, clk, arst_n, (valid_s1 && m_tvalid && !m_tready) |-> !s_tready, "input taken while both stages full")
	`SEWR_ASSERT(a_item_out, clk, arst_n, proc |=> m_tvalid, "processed item lost")
	`SEWR_NEVER(a_step_range, clk, arst_n, int'(step_cur) > STEPS - 1, "sweep step beyond last step")

endmodule

`default_nettype wire

// File: rtl/core/sewr_sweep.sv
// ----------------------------------------------------------------------------
// sewr_sweep
// sweep position state machine: stop, steady step or bouncing sweep
// ----------------------------------------------------------------------------
`default_nettype none

module sewr_sweep import sewr_pkg::*; #(
	parameter int STEPS = STEPS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire sweep_cmd_t                 cmd,
	output logic [$clog2(STEPS)-1:0]        step_cur,
	output logic [$clog2(STEPS)-1:0]        step_nxt
);

	localparam int SW = $clog2(STEPS);
	localparam logic [SW-1:0] TOP     = SW'(STEPS - 1);
	localparam logic [SW-1:0] TOP_M1  = SW'(STEPS - 2);
	localparam logic [SW-1:0] ONE     = SW'(1);
	localparam logic [SW-1:0] ZERO    = '0;

	sweep_state_t   state_q, state_d;
	logic           up_q, up_d;
	logic [SW-1:0]  step_q, step_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SW_STOPPED;
			up_q    <= 1'b1;
			step_q  <= ZERO;
		end else begin
			state_q <= state_d;
			up_q    <= up_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d = state_q;
		up_d    = up_q;
		step_d  = step_q;
		if (en && cmd.tick) begin
			case (state_q)
				SW_SWEEPING: begin
					if (up_q) begin
						if (step_q >= TOP) begin
							step_d = TOP_M1;
							up_d   = 1'b0;
						end else begin
							step_d = step_q + ONE;
						end
					end else begin
						if (step_q == ZERO) begin
							step_d = ONE;
							up_d   = 1'b1;
						end else begin
							step_d = step_q - ONE;
						end
					end
				end
				default: ;
			endcase
		end
		if (en && cmd.set_mode) begin
			case (mode_t'(cmd.mode))
				MODE_STOP: begin
					state_d = SW_STOPPED;
				end
				MODE_STEADY: begin
					state_d = SW_STEADY;
					// clamp the requested step to the last one
					if (int'(cmd.target) > STEPS - 1) begin
						step_d = TOP;
					end else begin
						step_d = SW'(cmd.target);
					end
				end
				MODE_SWEEP: begin
					state_d = SW_SWEEPING;
					up_d    = 1'b1;
					step_d  = ZERO;
				end
				default: ;
			endcase
		end
	end

	assign step_cur = step_q;
	assign step_nxt = step_d;

endmodule

`default_nettype wire

// File: rtl/core/sewr_range.sv
// ----------------------------------------------------------------------------
// sewr_range
// echo time to millimetres with saturation, and inclusive window check
// ----------------------------------------------------------------------------
`default_nettype none

module sewr_range import sewr_pkg::*; (
	input  wire logic [TS_W-1:0]    fall_us,
	input  wire logic [TS_W-1:0]    rise_us,
	input  wire logic [SCALE_W-1:0] scale_q16,
	input  wire logic [RANGE_W-1:0] range_min_mm,
	input  wire logic [RANGE_W-1:0] range_max_mm,
	output range_res_t              res
);

	localparam int PROD_W = TS_W + SCALE_W;

	logic [TS_W-1:0]    echo_us;
	logic [PROD_W-1:0]  prod;
	logic               sat;
	logic [RANGE_W-1:0] range_mm;

	// wraps across the timer rollover
	assign echo_us = fall_us - rise_us;
	assign prod    = {{SCALE_W{1'b0}}, echo_us} * {{TS_W{1'b0}}, scale_q16};
	// anything above bit 31 means the shifted value exceeds 16 bits
	assign sat      = |prod[PROD_W-1:TS_W];
	assign range_mm = sat ? {RANGE_W{1'b1}} : prod[TS_W-1:RANGE_W];

	assign res.range_mm = range_mm;
	assign res.in_win   = (range_mm >= range_min_mm) && (range_mm <= range_max_mm);

endmodule

`default_nettype wire
